[hw/rtl/otbk_pkg.sv]
// ----------------------------------------------------------------------------
// otbk_pkg - shared definitions for the one-shot timeout timer bank
// Sizes, operation codes, the command format passed from front to back and
// the back-end sequencer states.
// ----------------------------------------------------------------------------
package otbk_pkg;

  // Bank size (1 to 8 timers)
  localparam int unsigned NUM_TIMERS = 8;

  // Width of a timer index inside the bank
  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Fixed field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned TIDX_W   = 3;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned MASK_W   = 8;

  // Depth of the command queue between front and back
  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned CQ_PTR_W = 1;
  localparam int unsigned CQ_CNT_W = 2;

  // Operation codes on the input
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Classified command kinds
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [IDX_W-1:0]      idx;
    logic [PERIOD_W-1:0]   period;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DONE
  } bk_state_e;

endpackage

[hw/rtl/otbk_front.sv]
// ----------------------------------------------------------------------------
// otbk_front - input side of the timer bank
// Accepts input beats, classifies each into a command (ignored codes and
// out-of-range timers become no-ops) and holds them in a short queue.
// ----------------------------------------------------------------------------
module otbk_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [otbk_pkg::OP_W-1:0]      op_i,
  input  logic [otbk_pkg::TIDX_W-1:0]    timer_index_i,
  input  logic [otbk_pkg::PERIOD_W-1:0]  period_value_i,
  output logic                           cmd_valid_o,
  output otbk_pkg::cmd_t                 cmd_o,
  input  logic                           cmd_pop_i
);
  import otbk_pkg::*;

  cmd_t                cmd_in;
  logic                in_range;
  logic                wr_en;
  cmd_t                cq_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_CNT_W-1:0] cnt_q, cnt_d;

  // Classify the incoming beat
  always_comb begin
    in_range      = ({{(32-TIDX_W){1'b0}}, timer_index_i} < NUM_TIMERS);
    cmd_in.idx    = IDX_W'(timer_index_i);
    cmd_in.period = period_value_i;
    unique case (op_e'(op_i))
      OP_TICK:  cmd_in.kind = CMD_TICK;
      OP_START: cmd_in.kind = in_range ? CMD_START : CMD_NOP;
      OP_STOP:  cmd_in.kind = in_range ? CMD_STOP : CMD_NOP;
      OP_NONE:  cmd_in.kind = CMD_NOP;
      default:  cmd_in.kind = CMD_NOP;
    endcase
  end

  // Queue status and pointer advance
  assign full        = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
  assign wr_en       = push && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cq_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CQ_CNT_W'(wr_en) - CQ_CNT_W'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cq_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

[hw/rtl/otbk_back.sv]
// ----------------------------------------------------------------------------
// otbk_back - execution side of the timer bank
// Applies start and stop commands, walks every timer entry on a tick through
// one shared increment and compare, and loads the result register.
// ----------------------------------------------------------------------------
module otbk_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  otbk_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [otbk_pkg::MASK_W-1:0]   expired_mask_o,
  output logic [otbk_pkg::MASK_W-1:0]   running_mask_o
);
  import otbk_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NUM_TIMERS - 1);

  bk_state_e             state_q, state_d;
  logic [PERIOD_W-1:0]   count_q  [NUM_TIMERS];
  logic [PERIOD_W-1:0]   period_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] run_q;
  logic [IDX_W-1:0]      walk_q;
  logic [MASK_W-1:0]     exp_q;
  logic                  res_valid_q;
  logic [MASK_W-1:0]     res_exp_q;
  logic [MASK_W-1:0]     res_run_q;

  logic                  slot_free;
  logic                  do_start, do_stop, do_tick, do_step, do_load;
  logic [PERIOD_W-1:0]   count_sel, period_sel, count_inc;
  logic                  hit;

  assign slot_free = !res_valid_q || pop;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (cmd_valid_i) state_d = (cmd_i.kind == CMD_TICK) ? BK_WALK : BK_DONE;
      BK_WALK: if (walk_q == LastIdx) state_d = BK_DONE;
      BK_DONE: if (slot_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    do_start  = 1'b0;
    do_stop   = 1'b0;
    do_tick   = 1'b0;
    do_step   = 1'b0;
    do_load   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        do_start  = cmd_valid_i && (cmd_i.kind == CMD_START);
        do_stop   = cmd_valid_i && (cmd_i.kind == CMD_STOP);
        do_tick   = cmd_valid_i && (cmd_i.kind == CMD_TICK);
      end
      BK_WALK: do_step = 1'b1;
      BK_DONE: do_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shared increment and compare for the entry under the walk pointer
  assign count_sel  = count_q[walk_q];
  assign period_sel = period_q[walk_q];
  assign count_inc  = count_sel + PERIOD_W'(1);
  assign hit        = (count_inc >= period_sel);

  // Timer state: counts, run flags, walk pointer and expiry accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        count_q[i] <= '0;
      end
      run_q  <= '0;
      walk_q <= '0;
      exp_q  <= '0;
    end else begin
      if (do_start) begin
        count_q[cmd_i.idx] <= '0;
        run_q[cmd_i.idx]   <= 1'b1;
      end
      if (do_stop) begin
        count_q[cmd_i.idx] <= '0;
        run_q[cmd_i.idx]   <= 1'b0;
      end
      if (do_tick || do_start || do_stop || (cmd_pop_o && cmd_i.kind == CMD_NOP)) begin
        walk_q <= '0;
        exp_q  <= '0;
      end
      if (do_step) begin
        walk_q <= walk_q + 1'b1;
        if (run_q[walk_q]) begin
          if (hit) begin
            count_q[walk_q] <= '0;
            run_q[walk_q]   <= 1'b0;
            exp_q           <= exp_q | (MASK_W'(1) << walk_q);
          end else begin
            count_q[walk_q] <= count_inc;
          end
        end
      end
    end
  end

  // Load periods on start
  always_ff @(posedge clk_i) begin
    if (do_start) begin
      period_q[cmd_i.idx] <= cmd_i.period;
    end
  end

  // Result register: hold until popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (do_load) begin
      res_valid_q <= 1'b1;
    end else if (pop) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      res_exp_q <= exp_q;
      res_run_q <= MASK_W'(run_q);
    end
  end

  assign empty          = !res_valid_q;
  assign expired_mask_o = res_exp_q;
  assign running_mask_o = res_run_q;

endmodule

[hw/rtl/one_shot_timeout_timer_bank_core.sv]
// ----------------------------------------------------------------------------
// one_shot_timeout_timer_bank_core - bank of one-shot timeout timers
// Start, stop and tick items in, one expired/running mask pair out per item.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result. In the back end a start or
// stop goes from idle to the done state; a tick walks from idle through
// every timer entry to the done state, visiting one timer entry per cycle
// through a single shared 32-bit increment and compare. A two-beat command
// queue lets the input keep taking items while the back end works and a
// result register holds the finished beat until it is popped. Ignored items
// (op code 3, or a start or stop with a timer index beyond the bank) still
// give a result with an empty expired mask and the current running mask.
module one_shot_timeout_timer_bank_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [otbk_pkg::OP_W-1:0]      op_i,
  input  logic [otbk_pkg::TIDX_W-1:0]    timer_index_i,
  input  logic [otbk_pkg::PERIOD_W-1:0]  period_value_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [otbk_pkg::MASK_W-1:0]    expired_mask_o,
  output logic [otbk_pkg::MASK_W-1:0]    running_mask_o
);
  import otbk_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Accept and classify
  otbk_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .timer_index_i  (timer_index_i),
    .period_value_i (period_value_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  // Execute and report
  otbk_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .empty          (empty),
    .pop            (pop),
    .expired_mask_o (expired_mask_o),
    .running_mask_o (running_mask_o)
  );

`ifndef SYNTHESIS
  // A timer that expired is stopped in the same result
  a_expired_not_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((expired_mask_o & running_mask_o) == '0))
    else $error("expired timer still shown running");

  // The back end only takes a command that the queue holds
  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // A command taken by the back end never yields a result in the next cycle
  // while the result register was already full and not popped
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("pending result lost");
`endif

endmodule
